// ===== rtl/sbd_pkg.sv =====
package sbd_pkg;

  // Width of the two's complement integer taken per transaction.
  localparam int VALUE_BITS = 128;

  // Decimal digits needed for any magnitude below 2^VALUE_BITS
  // (VALUE_BITS * log10(2), rounded up).
  localparam int DIGIT_COUNT = (VALUE_BITS * 30103 + 99999) / 100000;

  localparam int BCD_BITS = DIGIT_COUNT * 4;
  localparam int CNT_W    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int REM_W    = $clog2(DIGIT_COUNT + 1);

  // Payload widths of the stream channels.
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 8;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [BCD_BITS-1:0]   bcd_t;
  typedef logic [3:0]            digit_t;

  // Commands from the sequencer to the conversion unit.
  typedef struct packed {
    logic load;   // take a new magnitude and clear the digits
    logic step;   // one shift-and-add-3 iteration
    logic shift;  // move the digits up by one place
  } dab_ctrl_t;

endpackage

// ===== rtl/sbd_dabble.sv =====
module sbd_dabble (
  input  logic               clk,
  input  sbd_pkg::dab_ctrl_t ctrl,
  input  sbd_pkg::value_t    load_value,
  output sbd_pkg::digit_t    top_digit
);

  sbd_pkg::value_t mag;
  sbd_pkg::bcd_t   bcd;
  sbd_pkg::bcd_t   bcd_adj;

  // Add 3 to every digit of 5 or more ahead of the doubling.
  always_comb begin
    for (int d = 0; d < sbd_pkg::DIGIT_COUNT; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  // Binary and decimal registers shift as one word, binary bit by bit into the digits.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= load_value;
      bcd <= '0;
    end else if (ctrl.step) begin
      mag <= {mag[sbd_pkg::VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[sbd_pkg::BCD_BITS-2:0], mag[sbd_pkg::VALUE_BITS-1]};
    end else if (ctrl.shift) begin
      bcd <= {bcd[sbd_pkg::BCD_BITS-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[sbd_pkg::BCD_BITS-1 -: 4];

endmodule

// ===== rtl/signed_binary_to_decimal_digits.sv =====
// Signed binary to decimal digit converter.
// Input stream (s_*): one transaction carries a 128-bit two's complement integer.
// Output stream (m_*): one transaction per character, most significant first:
// a leading minus sign for negative values, then the digits without leading
// zeros; m_tlast marks the final digit. Zero gives the single digit 0.
// Timing: the accepting cycle loads the magnitude, then shift-and-add-3 runs in
// the shared conversion unit, one input bit per step. Then leading zeros are
// dropped and the sequencer leaves that phase. A minus sign, if any, and then
// each digit are emitted while the receiver keeps m_tready high.
// s_tready is high only while the block is idle; the last character may still
// wait in the output register while the next value is taken.
// When the receiver stalls, the character in the output register holds and the
// sequencer waits. Synchronous reset returns to idle and drops any output.
module signed_binary_to_decimal_digits (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sbd_pkg::IN_DATA_W-1:0]    s_tdata,   // [63:0] value_low, [127:64] value_high
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sbd_pkg::OUT_DATA_W-1:0]   m_tdata,   // [0] is_minus, [4:1] digit, [7:5] zero
  output logic                             m_tlast    // last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SKIP  = 5'b00100,
    S_MINUS = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                    state, state_next;
  logic [sbd_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [sbd_pkg::REM_W-1:0] remain, remain_next;
  logic                      negative, negative_next;

  sbd_pkg::value_t    in_value;
  sbd_pkg::value_t    in_mag;
  sbd_pkg::dab_ctrl_t ctrl;
  sbd_pkg::digit_t    top_digit;

  logic in_fire;
  logic slot_free;
  logic load_out;
  logic [sbd_pkg::OUT_DATA_W-1:0] out_data_next;
  logic                           out_last_next;

  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // Magnitude of the incoming value; the most negative value stays as is.
  assign in_value = s_tdata[sbd_pkg::VALUE_BITS-1:0];
  assign in_mag   = in_value[sbd_pkg::VALUE_BITS-1] ?
                    (~in_value + sbd_pkg::value_t'(1)) : in_value;

  sbd_dabble u_dabble (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_value (in_mag),
    .top_digit  (top_digit)
  );

  // Sequencer: load, convert, drop leading zeros, emit characters.
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    remain_next   = remain;
    negative_next = negative;
    ctrl          = '0;
    load_out      = 1'b0;
    out_data_next = '0;
    out_last_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctrl.load     = 1'b1;
          negative_next = in_value[sbd_pkg::VALUE_BITS-1];
          cnt_next      = sbd_pkg::CNT_W'(sbd_pkg::VALUE_BITS - 1);
          state_next    = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt - 1'b1;
        if (cnt == '0) begin
          remain_next = sbd_pkg::REM_W'(sbd_pkg::DIGIT_COUNT);
          state_next  = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && remain > sbd_pkg::REM_W'(1)) begin
          ctrl.shift  = 1'b1;
          remain_next = remain - 1'b1;
        end else if (negative) begin
          state_next = S_MINUS;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_MINUS: begin
        if (slot_free) begin
          load_out      = 1'b1;
          out_data_next = {3'd0, 4'd0, 1'b1};
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out      = 1'b1;
          out_data_next = {3'd0, top_digit, 1'b0};
          out_last_next = (remain == sbd_pkg::REM_W'(1));
          ctrl.shift    = 1'b1;
          remain_next   = remain - 1'b1;
          if (remain == sbd_pkg::REM_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Counters, sign and output payload.
  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    remain   <= remain_next;
    negative <= negative_next;
    if (load_out) begin
      m_tdata <= out_data_next;
      m_tlast <= out_last_next;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 450;
  localparam int WAIT_MAX     = 8;
  localparam int PHASE_LEN    = 50;     // transactions per idling phase
  localparam int HOLD_AFTER   = 3000;   // characters seen before the long hold-off
  localparam int HOLD_CYCLES  = 1500;
  localparam int IDLE_LIMIT   = 20000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 300;    // cycles run after the last expected character has arrived

  // One decimal character as it leaves the block.
  typedef struct packed {
    logic            is_minus;
    sbd_pkg::digit_t digit;
    logic            last;
  } dec_char_t;

  typedef enum int {FULL_RANDOM, SHORT_MAGNITUDE, NEAR_POWER_OF_TEN, SMALL_VALUE} value_kind_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sbd_pkg::IN_DATA_W-1:0]  s_tdata  = '0;   // [63:0] value_low, [127:64] value_high
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sbd_pkg::OUT_DATA_W-1:0] m_tdata;         // [0] is_minus, [4:1] digit, [7:5] zero
  logic                           m_tlast;         // last

  sbd_pkg::value_t pending_values[$];
  dec_char_t       expected_chars[$];

  int items_total    = 0;
  int items_sent     = 0;
  int negatives_sent = 0;
  int longest_number = 0;
  int chars_checked  = 0;
  int mismatches     = 0;
  int send_wait      = 0;
  int recv_wait      = 0;
  bit send_fast      = 1'b0;
  bit recv_fast      = 1'b0;
  int hold_left      = 0;
  int hold_seen      = 0;
  bit hold_done      = 1'b0;
  int idle_cycles    = 0;

  signed_binary_to_decimal_digits dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // Appends an integer to the stimulus queue.
  function automatic void queue_value(sbd_pkg::value_t v);
    pending_values.insert(pending_values.size(), v);
  endfunction

  // Appends a character to the expected stream.
  function automatic void add_expected(dec_char_t c);
    expected_chars.insert(expected_chars.size(), c);
  endfunction

  // Works out the characters of one integer: optional minus sign, then the
  // digits most significant first, the final one marked.
  function automatic void predict_characters(sbd_pkg::value_t raw);
    sbd_pkg::value_t magnitude;
    sbd_pkg::digit_t digits[$];
    logic            negative;
    negative  = raw[sbd_pkg::VALUE_BITS-1];
    magnitude = negative ? (~raw + 1'b1) : raw;
    do begin
      digits.push_front(sbd_pkg::digit_t'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      add_expected(dec_char_t'{is_minus: 1'b1, digit: 4'd0, last: 1'b0});
      negatives_sent++;
    end
    foreach (digits[i]) begin
      add_expected(dec_char_t'{is_minus: 1'b0, digit: digits[i],
                               last: (i == digits.size() - 1)});
    end
    if (digits.size() + negative > longest_number) begin
      longest_number = digits.size() + negative;
    end
  endfunction

  function automatic sbd_pkg::value_t power_of_ten(int exponent);
    sbd_pkg::value_t v;
    v = 1;
    repeat (exponent) v = v * 10;
    return v;
  endfunction

  // Random integer drawn from one of several shapes so that every digit count
  // and both signs come up often.
  function automatic sbd_pkg::value_t random_value();
    sbd_pkg::value_t v;
    value_kind_t     kind;
    int              bits;
    v    = {$urandom, $urandom, $urandom, $urandom};
    kind = value_kind_t'($urandom_range(0, 3));
    case (kind)
      FULL_RANDOM: begin
      end
      SHORT_MAGNITUDE: begin
        bits = $urandom_range(1, sbd_pkg::VALUE_BITS - 1);
        v = v & ((sbd_pkg::value_t'(1) << bits) - 1'b1);
        if ($urandom_range(0, 1)) v = -v;
      end
      NEAR_POWER_OF_TEN: begin
        v = power_of_ten($urandom_range(0, 38)) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = sbd_pkg::value_t'($urandom_range(0, 999));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Sender: presents queued integers, waiting a drawn number of cycles after
  // each transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else if (s_tvalid && s_tready) begin
      predict_characters(s_tdata[sbd_pkg::VALUE_BITS-1:0]);
      items_sent++;
      if (items_sent % PHASE_LEN == 0) send_fast = ($urandom_range(0, 2) == 0);
      send_wait = send_fast ? 0 : $urandom_range(0, WAIT_MAX);
      if (send_wait == 0 && pending_values.size() > 0) begin
        s_tdata <= pending_values.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end else if (!s_tvalid) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending_values.size() > 0) begin
        s_tdata  <= pending_values.pop_front();
        s_tvalid <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, started once after enough characters have passed.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) hold_seen <= hold_seen + 1;
      if (!hold_done && hold_seen >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Receiver: checks each character against the oldest expectation and
  // stalls a drawn number of cycles after each transaction.
  always @(posedge clk) begin
    dec_char_t got;
    dec_char_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = dec_char_t'{is_minus: m_tdata[0], digit: m_tdata[4:1], last: m_tlast};
        chars_checked++;
        if (m_tdata[7:5] != 3'd0) begin
          $error("pad: expected 0, actual %0d", m_tdata[7:5]);
          mismatches++;
        end
        if (expected_chars.size() == 0) begin
          $error("unexpected character: is_minus %0d digit %0d last %0d",
                 got.is_minus, got.digit, got.last);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (got.is_minus !== want.is_minus) begin
            $error("is_minus: expected %0d, actual %0d", want.is_minus, got.is_minus);
            mismatches++;
          end
          if (got.digit !== want.digit) begin
            $error("digit: expected %0d, actual %0d", want.digit, got.digit);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
          end
        end
        if (chars_checked % PHASE_LEN == 0) recv_fast = ($urandom_range(0, 2) == 0);
        recv_wait = recv_fast ? 0 : $urandom_range(0, WAIT_MAX);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_tready <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles.", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    sbd_pkg::value_t most_negative;
    most_negative = sbd_pkg::value_t'(1) << (sbd_pkg::VALUE_BITS - 1);

    // Directed integers: zero, ones, digit boundaries, word boundaries and
    // the signed extremes, the most negative value among them.
    queue_value(sbd_pkg::value_t'(0));
    queue_value(sbd_pkg::value_t'(1));
    queue_value(sbd_pkg::value_t'(9));
    queue_value(sbd_pkg::value_t'(10));
    queue_value(sbd_pkg::value_t'(100));
    queue_value(sbd_pkg::value_t'(1000000007));
    queue_value(-sbd_pkg::value_t'(1));
    queue_value(-sbd_pkg::value_t'(9));
    queue_value(-sbd_pkg::value_t'(10));
    queue_value(sbd_pkg::value_t'(1) << 63);
    queue_value((sbd_pkg::value_t'(1) << 64) - 1'b1);
    queue_value(sbd_pkg::value_t'(1) << 64);
    queue_value(-(sbd_pkg::value_t'(1) << 64));
    queue_value(power_of_ten(19) - 1'b1);
    queue_value(power_of_ten(19));
    queue_value(power_of_ten(38) - 1'b1);
    queue_value(power_of_ten(38));
    queue_value(-power_of_ten(38));
    queue_value(~most_negative);
    queue_value(most_negative);
    queue_value(most_negative + 1'b1);
    queue_value({32{4'h5}});
    queue_value({32{4'hA}});
    for (int i = 0; i < RANDOM_ITEMS; i++) queue_value(random_value());
    items_total = pending_values.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (items_sent < items_total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (%0d negative), checked %0d characters, longest %0d.",
             items_sent, negatives_sent, chars_checked, longest_number);
    $display("Receiver held off once for %0d cycles while input kept coming.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
